/* rtl/arc_point_sampler_core_assert.svh */
// Assertion macros for the arc point sampler
`ifndef ARC_POINT_SAMPLER_CORE_ASSERT_SVH
`define ARC_POINT_SAMPLER_CORE_ASSERT_SVH
// Implication checked on every clock edge, quiet in reset
`define APS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked on every clock edge, quiet in reset
`define APS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/aps_pkg.sv */
// ---------------------------------------------------------------------------
// aps_pkg
// Shared constants, register indexes and arctangent table for the arc sampler.
// ---------------------------------------------------------------------------
`default_nettype none
package aps_pkg;
	localparam int RotateStagesDef = 32;
	localparam int CoordW = 32;
	localparam int VecW = 33;
	localparam int AngW = 32;
	localparam int PosW = 17;
	localparam int TolW = 24;
	localparam int IdxW = 3;
	// Working width of the CORDIC datapath: 33 bits, 8 guard bits, growth
	localparam int CordW = 44;
	localparam logic [29:0] InvGain = 30'd652032874;
	localparam logic [PosW-1:0] PosOne = 17'd65536;

	typedef enum logic [IdxW-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_START_X  = 3'd2,
		REG_START_Y  = 3'd3,
		REG_END_X    = 3'd4,
		REG_END_Y    = 3'd5,
		REG_CW       = 3'd6,
		REG_TOL      = 3'd7
	} reg_idx_t;

	// Arctangent of 2^-i in binary angle units, zero beyond the table
	function automatic logic [AngW-1:0] atan_step(input int i);
		logic [AngW-1:0] tab [32];
		tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
			32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
		if (i < 32) begin
			return tab[i];
		end
		return '0;
	endfunction
endpackage
`default_nettype wire

/* rtl/aps_vector_cordic.sv */
// ---------------------------------------------------------------------------
// aps_vector_cordic
// Pipelined CORDIC vectoring: angle of a 33-bit vector, one stage per step.
// ---------------------------------------------------------------------------
`default_nettype none
module aps_vector_cordic #(
	parameter int Stages = aps_pkg::RotateStagesDef
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic signed [aps_pkg::VecW-1:0] vec_x,
	input  wire logic signed [aps_pkg::VecW-1:0] vec_y,
	output logic                          out_valid,
	output logic [aps_pkg::AngW-1:0]      angle
);
	import aps_pkg::*;

	logic                     vld_s [Stages+1];
	logic signed [CordW-1:0]  x_s   [Stages+1];
	logic signed [CordW-1:0]  y_s   [Stages+1];
	logic [AngW-1:0]          z_s   [Stages+1];
	logic                     zero_s[Stages+1];

	// Fold the left half-plane and scale by the guard bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		zero_s[0] <= (vec_x == '0) && (vec_y == '0);
		if (vec_x < 0) begin
			x_s[0] <= -(CordW'(vec_x) <<< 8);
			y_s[0] <= -(CordW'(vec_y) <<< 8);
			z_s[0] <= 32'h80000000;
		end else begin
			x_s[0] <= CordW'(vec_x) <<< 8;
			y_s[0] <= CordW'(vec_y) <<< 8;
			z_s[0] <= '0;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < Stages; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_step(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_step(i);
			end
		end
	end

	assign out_valid = vld_s[Stages];
	assign angle = zero_s[Stages] ? '0 : z_s[Stages];
endmodule
`default_nettype wire

/* rtl/aps_sweep.sv */
// ---------------------------------------------------------------------------
// aps_sweep
// Sweep selection and rotation angle: two register stages around the multiply.
// ---------------------------------------------------------------------------
`default_nettype none
module aps_sweep (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [aps_pkg::AngW-1:0]  ang_start,
	input  wire logic [aps_pkg::AngW-1:0]  ang_end,
	input  wire logic [aps_pkg::PosW-1:0]  position,
	input  wire logic                      clockwise,
	input  wire logic [aps_pkg::TolW-1:0]  angle_tolerance,
	output logic                           out_valid,
	output logic [aps_pkg::AngW-1:0]       theta
);
	import aps_pkg::*;

	logic [AngW-1:0]    d;
	logic signed [33:0] a;
	logic [AngW-1:0]    mag;
	logic               vld_s1, vld_s2;
	logic signed [33:0] a_s1;
	logic [PosW-1:0]    pos_s1;
	logic signed [51:0] prod;
	logic [AngW-1:0]    theta_s2;

	// Choose the sweep from the wrapped angle difference
	always_comb begin
		d = ang_end - ang_start;
		a = 34'(signed'(d));
		mag = d[AngW-1] ? (~d + 32'd1) : d;
		if (!(d[AngW-1] && d == 32'h80000000) && mag <= 32'(angle_tolerance)) begin
			a = clockwise ? -34'sh100000000 : 34'sh100000000;
		end else if (clockwise) begin
			if (a > 0) begin
				a = a - 34'sh100000000;
			end
		end else if (a < 0) begin
			a = a + 34'sh100000000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Saturate the position and register the operands
	always_ff @(posedge clk) begin
		a_s1 <= a;
		pos_s1 <= (position > PosOne) ? PosOne : position;
	end

	// Scale and round the rotation angle
	assign prod = 52'(a_s1) * $signed({1'b0, pos_s1}) + 52'sd32768;
	always_ff @(posedge clk) begin
		theta_s2 <= prod[47:16];
	end

	assign out_valid = vld_s2;
	assign theta = theta_s2;
endmodule
`default_nettype wire

/* rtl/aps_rotate_cordic.sv */
// ---------------------------------------------------------------------------
// aps_rotate_cordic
// Pipelined CORDIC rotation with quarter-turn pre-rotation and gain scaling.
// ---------------------------------------------------------------------------
`default_nettype none
module aps_rotate_cordic #(
	parameter int Stages = aps_pkg::RotateStagesDef
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic signed [aps_pkg::VecW-1:0] vec_x,
	input  wire logic signed [aps_pkg::VecW-1:0] vec_y,
	input  wire logic [aps_pkg::AngW-1:0]        theta,
	output logic                                 out_valid,
	output logic signed [aps_pkg::VecW+1:0]      rot_x,
	output logic signed [aps_pkg::VecW+1:0]      rot_y
);
	import aps_pkg::*;

	logic [1:0]              q;
	logic signed [VecW:0]    px, py;
	logic                    vld_p;
	logic signed [VecW:0]    x_p, y_p;
	logic [AngW-1:0]         z_p;
	logic signed [64:0]      mx, my;
	logic                    vld_s [Stages+1];
	logic signed [CordW-1:0] x_s   [Stages+1];
	logic signed [CordW-1:0] y_s   [Stages+1];
	logic signed [AngW-1:0]  z_s   [Stages+1];
	logic signed [CordW-1:0] rx, ry;

	// Quarter-turn pre-rotation
	always_comb begin
		q = 2'(32'(theta + 32'h20000000) >> 30);
		px = (VecW+1)'(vec_x);
		py = (VecW+1)'(vec_y);
		unique case (q)
			2'd1: begin px = -(VecW+1)'(vec_y); py = (VecW+1)'(vec_x); end
			2'd2: begin px = -(VecW+1)'(vec_x); py = -(VecW+1)'(vec_y); end
			2'd3: begin px = (VecW+1)'(vec_y); py = -(VecW+1)'(vec_x); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_p <= in_valid;
			vld_s[0] <= vld_p;
		end
	end
	always_ff @(posedge clk) begin
		x_p <= px;
		y_p <= py;
		z_p <= theta - {q, 30'd0};
	end

	// Scale by the inverse gain, keep 8 guard bits
	assign mx = 65'(x_p) * $signed({1'b0, InvGain});
	assign my = 65'(y_p) * $signed({1'b0, InvGain});
	always_ff @(posedge clk) begin
		x_s[0] <= CordW'(mx >>> 22);
		y_s[0] <= CordW'(my >>> 22);
		z_s[0] <= z_p;
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < Stages; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - $signed(atan_step(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + $signed(atan_step(i));
			end
		end
	end

	// Round off the guard bits
	assign rx = (x_s[Stages] + 44'sd128) >>> 8;
	assign ry = (y_s[Stages] + 44'sd128) >>> 8;
	assign out_valid = vld_s[Stages];
	assign rot_x = (VecW+2)'(rx);
	assign rot_y = (VecW+2)'(ry);
endmodule
`default_nettype wire

/* rtl/arc_point_sampler_core.sv */
// ---------------------------------------------------------------------------
// arc_point_sampler_core
// Samples points along a configured circular arc, one item per clock.
// ---------------------------------------------------------------------------
// Usage: one position item may be started every cycle (busy is always low).
// Each item's point appears on point_x/point_y with done high for one cycle,
// after the two vector-angle CORDICs, the sweep stages, the rotation CORDIC and
// the registered centre add with saturation. The receiver cannot
// stall the block. Change configuration only when no item is in flight.
`default_nettype none
module arc_point_sampler_core #(
	parameter int RotateStages = aps_pkg::RotateStagesDef
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [aps_pkg::PosW-1:0]            position,
	output logic                                     done,
	output logic signed [aps_pkg::CoordW-1:0]        point_x,
	output logic signed [aps_pkg::CoordW-1:0]        point_y,
	input  wire logic                                cfg_we,
	input  wire logic [aps_pkg::IdxW-1:0]            cfg_index,
	input  wire logic [aps_pkg::CoordW-1:0]          cfg_data
);
	import aps_pkg::*;
	`include "arc_point_sampler_core_assert.svh"

	localparam int VecLat = RotateStages + 1;

	logic signed [CoordW-1:0] center_x_q, center_y_q, start_x_q, start_y_q;
	logic signed [CoordW-1:0] end_x_q, end_y_q;
	logic                     clockwise_q;
	logic [TolW-1:0]          tol_q;
	logic                     accept;
	logic signed [VecW-1:0]   v1x, v1y, v2x, v2y;
	logic                     va_vld, vb_vld, sw_vld, rot_vld;
	logic [AngW-1:0]          ang1, ang2, theta;
	logic [PosW-1:0]          pos_d_q [VecLat];
	logic signed [VecW+1:0]   rot_x, rot_y;
	logic signed [VecW+2:0]   sum_x, sum_y;
	logic                     done_q;
	logic signed [CoordW-1:0] px_q, py_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0; center_y_q <= '0;
			start_x_q <= '0; start_y_q <= '0;
			end_x_q <= '0; end_y_q <= '0;
			clockwise_q <= 1'b0;
			tol_q <= TolW'(16);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_START_X:  start_x_q <= cfg_data;
				REG_START_Y:  start_y_q <= cfg_data;
				REG_END_X:    end_x_q <= cfg_data;
				REG_END_Y:    end_y_q <= cfg_data;
				REG_CW:       clockwise_q <= cfg_data[0];
				REG_TOL:      tol_q <= cfg_data[TolW-1:0];
				default: ;
			endcase
		end
	end

	assign v1x = VecW'(start_x_q) - VecW'(center_x_q);
	assign v1y = VecW'(start_y_q) - VecW'(center_y_q);
	assign v2x = VecW'(end_x_q) - VecW'(center_x_q);
	assign v2y = VecW'(end_y_q) - VecW'(center_y_q);

	aps_vector_cordic #(.Stages(RotateStages)) u_vec_start (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.vec_x(v1x), .vec_y(v1y), .out_valid(va_vld), .angle(ang1));
	aps_vector_cordic #(.Stages(RotateStages)) u_vec_end (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.vec_x(v2x), .vec_y(v2y), .out_valid(vb_vld), .angle(ang2));

	// Delay the position alongside the angle pipelines
	always_ff @(posedge clk) begin
		pos_d_q[0] <= position;
		for (int i = 1; i < VecLat; i++) begin
			pos_d_q[i] <= pos_d_q[i-1];
		end
	end

	aps_sweep u_sweep (
		.clk(clk), .arst_n(arst_n), .in_valid(va_vld && vb_vld),
		.ang_start(ang1), .ang_end(ang2), .position(pos_d_q[VecLat-1]),
		.clockwise(clockwise_q), .angle_tolerance(tol_q),
		.out_valid(sw_vld), .theta(theta));

	aps_rotate_cordic #(.Stages(RotateStages)) u_rot (
		.clk(clk), .arst_n(arst_n), .in_valid(sw_vld),
		.vec_x(v1x), .vec_y(v1y), .theta(theta),
		.out_valid(rot_vld), .rot_x(rot_x), .rot_y(rot_y));

	// Add the centre and saturate
	assign sum_x = (VecW+3)'(rot_x) + (VecW+3)'(center_x_q);
	assign sum_y = (VecW+3)'(rot_y) + (VecW+3)'(center_y_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rot_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (sum_x > 36'sh07FFFFFFF) begin
			px_q <= 32'h7FFFFFFF;
		end else if (sum_x < -36'sh080000000) begin
			px_q <= 32'h80000000;
		end else begin
			px_q <= sum_x[CoordW-1:0];
		end
		if (sum_y > 36'sh07FFFFFFF) begin
			py_q <= 32'h7FFFFFFF;
		end else if (sum_y < -36'sh080000000) begin
			py_q <= 32'h80000000;
		end else begin
			py_q <= sum_y[CoordW-1:0];
		end
	end

	assign done = done_q;
	assign point_x = px_q;
	assign point_y = py_q;

	`APS_ASSERT_IMP(a_vec_pair, va_vld, vb_vld)
	`APS_ASSERT_NXT(a_done_follows, rot_vld, done)
	`APS_ASSERT_IMP(a_never_busy, start, !busy)
endmodule
`default_nettype wire
